// ----- design/hsv2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Shared types and constants of the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

	localparam int unsigned HueWidth   = 16;
	localparam int unsigned ChanWidth  = 8;
	localparam int unsigned AngleWidth = 9;
	localparam int unsigned FracWidth  = 8;

	localparam int unsigned HueTurn    = 360;
	localparam int unsigned SectorDeg  = 60;
	localparam int unsigned ChanMax    = 255;
	localparam int unsigned ChanShift  = 8;

	// floor(hue / 360) ~ (hue * RecipMul) >> RecipShift, low by at most one
	localparam int unsigned RecipShift = 24;
	localparam int unsigned RecipMul   = (1 << RecipShift) / HueTurn;
	localparam int unsigned QuotWidth  = 8;

	typedef enum logic [2:0] {
		SEC_RED_RISE   = 3'd0,
		SEC_GREEN_FALL = 3'd1,
		SEC_GREEN_RISE = 3'd2,
		SEC_BLUE_FALL  = 3'd3,
		SEC_BLUE_RISE  = 3'd4,
		SEC_RED_FALL   = 3'd5
	} sector_t;

	typedef struct packed {
		logic [HueWidth-1:0]  hue;
		logic [ChanWidth-1:0] saturation;
		logic [ChanWidth-1:0] brightness;
	} hsv_t;

	typedef struct packed {
		logic [ChanWidth-1:0] red;
		logic [ChanWidth-1:0] green;
		logic [ChanWidth-1:0] blue;
	} rgb_t;

	typedef struct packed {
		sector_t              sector;
		logic [FracWidth-1:0] frac;
		logic [ChanWidth-1:0] saturation;
		logic [ChanWidth-1:0] brightness;
	} split_t;

endpackage

// ----- design/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Integer HSV to 8-bit RGB pixel converter, six pipeline stages.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+---------------------------------
//  input   | hsv_valid | hsv_stall | hsv : hue, saturation, brightness
//  output  | rgb_valid | rgb_stall | rgb : red, green, blue
//
//  One pixel per clock while no stall holds the pipeline.
//  Stages: hue reciprocal multiply, modulo correction, sector split,
//  first level multiplies, second level multiplies, channel select.
//  Reset clears the stage valid bits only; no state is kept between pixels.
//  A stall holds every full stage behind it; empty stages keep filling.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              hsv_valid,
	output logic              hsv_stall,
	input  hsv2rgb_pkg::hsv_t hsv,
	output logic              rgb_valid,
	input  logic              rgb_stall,
	output hsv2rgb_pkg::rgb_t rgb
);
	import hsv2rgb_pkg::*;

	localparam int unsigned MulWidth = 2 * ChanWidth;

	logic   split_valid;
	logic   split_stall;
	split_t split;

	logic valid_s4, valid_s5, valid_s6;
	logic ready_s4, ready_s5, ready_s6;

	sector_t              sector_s4, sector_s5;
	logic [ChanWidth-1:0] sat_s4, bri_s4, sat_s5, bri_s5;
	logic [ChanWidth-1:0] att_fall_s4, att_rise_s4, lo_s4;
	logic [ChanWidth-1:0] fall_s5, rise_s5, lo_s5;
	rgb_t                 rgb_s6;

	logic [MulWidth-1:0]  mul_fall, mul_rise, mul_lo;
	logic [MulWidth-1:0]  mul_lvl_fall, mul_lvl_rise;
	rgb_t                 rgb_c;

	hsv2rgb_hue_split u_hue_split (
		.clk         (clk),
		.arst_n      (arst_n),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall),
		.hsv         (hsv),
		.split_valid (split_valid),
		.split_stall (split_stall),
		.split       (split)
	);

	assign ready_s6    = !valid_s6 || !rgb_stall;
	assign ready_s5    = !valid_s5 || ready_s6;
	assign ready_s4    = !valid_s4 || ready_s5;
	assign split_stall = !ready_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s4) valid_s4 <= split_valid;
			if (ready_s5) valid_s5 <= valid_s4;
			if (ready_s6) valid_s6 <= valid_s5;
		end
	end

	always_comb begin
		mul_fall = MulWidth'(split.saturation) * MulWidth'(split.frac);
		mul_rise = MulWidth'(split.saturation) * MulWidth'(ChanWidth'(ChanMax) - split.frac);
		mul_lo   = MulWidth'(split.brightness) *
		           MulWidth'(ChanWidth'(ChanMax) - split.saturation);
	end

	always_ff @(posedge clk) begin
		if (ready_s4) begin
			sector_s4   <= split.sector;
			sat_s4      <= split.saturation;
			bri_s4      <= split.brightness;
			att_fall_s4 <= mul_fall[ChanShift +: ChanWidth];
			att_rise_s4 <= mul_rise[ChanShift +: ChanWidth];
			lo_s4       <= mul_lo[ChanShift +: ChanWidth];
		end
	end

	always_comb begin
		mul_lvl_fall = MulWidth'(bri_s4) * MulWidth'(ChanWidth'(ChanMax) - att_fall_s4);
		mul_lvl_rise = MulWidth'(bri_s4) * MulWidth'(ChanWidth'(ChanMax) - att_rise_s4);
	end

	always_ff @(posedge clk) begin
		if (ready_s5) begin
			sector_s5 <= sector_s4;
			sat_s5    <= sat_s4;
			bri_s5    <= bri_s4;
			fall_s5   <= mul_lvl_fall[ChanShift +: ChanWidth];
			rise_s5   <= mul_lvl_rise[ChanShift +: ChanWidth];
			lo_s5     <= lo_s4;
		end
	end

	always_comb begin
		case (sector_s5)
			SEC_RED_RISE:   rgb_c = '{red: bri_s5,  green: rise_s5, blue: lo_s5};
			SEC_GREEN_FALL: rgb_c = '{red: fall_s5, green: bri_s5,  blue: lo_s5};
			SEC_GREEN_RISE: rgb_c = '{red: lo_s5,   green: bri_s5,  blue: rise_s5};
			SEC_BLUE_FALL:  rgb_c = '{red: lo_s5,   green: fall_s5, blue: bri_s5};
			SEC_BLUE_RISE:  rgb_c = '{red: rise_s5, green: lo_s5,   blue: bri_s5};
			default:        rgb_c = '{red: bri_s5,  green: lo_s5,   blue: fall_s5};
		endcase
		// gray
		if (sat_s5 == '0) begin
			rgb_c = '{red: bri_s5, green: bri_s5, blue: bri_s5};
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s6) begin
			rgb_s6 <= rgb_c;
		end
	end

	assign rgb_valid = valid_s6;
	assign rgb       = rgb_s6;

endmodule

// ----- design/hsv2rgb_hue_split.sv -----
// ----------------------------------------------------------------------------
// hsv2rgb_hue_split
// Three-stage pipeline: hue modulo 360, then 60-degree sector and a
// remainder scaled to 0..250.
// ----------------------------------------------------------------------------
module hsv2rgb_hue_split (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                hsv_valid,
	output logic                hsv_stall,
	input  hsv2rgb_pkg::hsv_t   hsv,
	output logic                split_valid,
	input  logic                split_stall,
	output hsv2rgb_pkg::split_t split
);
	import hsv2rgb_pkg::*;

	localparam int unsigned ProdWidth = HueWidth + 16;
	localparam int unsigned RemWidth  = HueWidth + 1;
	localparam int unsigned R60Width  = 6;

	logic valid_s1, valid_s2, valid_s3;
	logic ready_s1, ready_s2, ready_s3;

	logic [QuotWidth-1:0]  quot_s1;
	hsv_t                  pix_s1;
	logic [AngleWidth-1:0] angle_s2;
	logic [ChanWidth-1:0]  sat_s2, bri_s2;
	split_t                split_s3;

	logic [ProdWidth-1:0]  recip_prod;
	logic [RemWidth-1:0]   rem_full;
	logic [RemWidth-1:0]   rem_fix;
	sector_t               sector_c;
	logic [AngleWidth-1:0] base_c;
	logic [R60Width-1:0]   r60_c;
	logic [R60Width+4:0]   r60_x17;

	assign ready_s3  = !valid_s3 || !split_stall;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign hsv_stall = !ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= hsv_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// estimate the turn count
	assign recip_prod = ProdWidth'(hsv.hue) * ProdWidth'(RecipMul);

	always_ff @(posedge clk) begin
		if (ready_s1) begin
			quot_s1 <= recip_prod[RecipShift +: QuotWidth];
			pix_s1  <= hsv;
		end
	end

	// remainder, then correct the one-low estimate
	always_comb begin
		rem_full = RemWidth'(pix_s1.hue) - RemWidth'(quot_s1) * RemWidth'(HueTurn);
		rem_fix  = (rem_full >= RemWidth'(HueTurn)) ? rem_full - RemWidth'(HueTurn)
		                                            : rem_full;
	end

	always_ff @(posedge clk) begin
		if (ready_s2) begin
			angle_s2 <= rem_fix[AngleWidth-1:0];
			sat_s2   <= pix_s1.saturation;
			bri_s2   <= pix_s1.brightness;
		end
	end

	// sector by compare, fraction = r60 * 255 / 60 = (r60 * 17) >> 2
	always_comb begin
		if (angle_s2 >= AngleWidth'(5 * SectorDeg)) begin
			sector_c = SEC_RED_FALL;
			base_c   = AngleWidth'(5 * SectorDeg);
		end else if (angle_s2 >= AngleWidth'(4 * SectorDeg)) begin
			sector_c = SEC_BLUE_RISE;
			base_c   = AngleWidth'(4 * SectorDeg);
		end else if (angle_s2 >= AngleWidth'(3 * SectorDeg)) begin
			sector_c = SEC_BLUE_FALL;
			base_c   = AngleWidth'(3 * SectorDeg);
		end else if (angle_s2 >= AngleWidth'(2 * SectorDeg)) begin
			sector_c = SEC_GREEN_RISE;
			base_c   = AngleWidth'(2 * SectorDeg);
		end else if (angle_s2 >= AngleWidth'(SectorDeg)) begin
			sector_c = SEC_GREEN_FALL;
			base_c   = AngleWidth'(SectorDeg);
		end else begin
			sector_c = SEC_RED_RISE;
			base_c   = '0;
		end
		r60_c   = R60Width'(angle_s2 - base_c);
		r60_x17 = {1'b0, r60_c, 4'b0000} + (R60Width+5)'(r60_c);
	end

	always_ff @(posedge clk) begin
		if (ready_s3) begin
			split_s3.sector     <= sector_c;
			split_s3.frac       <= r60_x17[2 +: FracWidth];
			split_s3.saturation <= sat_s2;
			split_s3.brightness <= bri_s2;
		end
	end

	assign split_valid = valid_s3;
	assign split       = split_s3;

endmodule
